FILE: design/lei_pkg.sv
// Shared constants, types and helper functions of the Lorenz Euler integrator.
package lei_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int LOAD_W    = 32;
  localparam int COEF_FRAC = 16;
  localparam int DT_FRAC   = 24;

  localparam int SIGMA_W   = 23;
  localparam int RHO_W     = 22;
  localparam int BETA_W    = 22;
  localparam int DT_W      = 25;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;

  localparam int MUL_W  = COORD_W + 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DER_W  = 2 * COORD_W - FRAC_BITS + 2;
  localparam int HI_W   = DER_W - DT_FRAC;
  localparam int ACC_W  = HI_W + DT_W + 1;
  localparam int SUM_W  = DER_W + 4;

  localparam int ALIGN_L = (FRAC_BITS >= COEF_FRAC) ? FRAC_BITS - COEF_FRAC : 0;
  localparam int ALIGN_R = (FRAC_BITS >= COEF_FRAC) ? 0 : COEF_FRAC - FRAC_BITS;

  localparam logic signed [SUM_W-1:0] COORD_MAX =
    {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] COORD_MIN = ~COORD_MAX;

  localparam logic signed [COORD_W-1:0] COORD_ONE =
    {{(COORD_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA = 2'd0,
    REG_RHO   = 2'd1,
    REG_BETA  = 2'd2,
    REG_DT    = 2'd3
  } reg_idx_t;

  // One code per pass through the shared multiplier, in issue order.
  typedef enum logic [3:0] {
    ST_DX  = 4'd0,
    ST_DYA = 4'd1,
    ST_DZA = 4'd2,
    ST_DZB = 4'd3,
    ST_XH  = 4'd4,
    ST_XL  = 4'd5,
    ST_YH  = 4'd6,
    ST_YL  = 4'd7,
    ST_ZH  = 4'd8,
    ST_ZL  = 4'd9
  } step_t;

  typedef struct packed {
    logic  ready;
    logic  issue;
    step_t issue_step;
    logic  cons;
    step_t cons_step;
    logic  deliver;
  } ctrl_t;

  typedef struct packed {
    logic               clip;
    logic [COORD_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_coord(input logic signed [SUM_W-1:0] v);
    sat_t r;
    if (v > COORD_MAX) begin
      r.clip = 1'b1;
      r.val  = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r.clip = 1'b1;
      r.val  = COORD_MIN[COORD_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Brings a Q16.16 coefficient to the point's fraction width, flooring when narrowing.
  function automatic logic signed [MUL_W-1:0] align_coef(input logic signed [MUL_W-1:0] v);
    logic signed [MUL_W-1:0] r;
    if (FRAC_BITS >= COEF_FRAC) begin
      r = v <<< ALIGN_L;
    end else begin
      r = v >>> ALIGN_R;
    end
    return r;
  endfunction

endpackage

FILE: design/lei_if.sv
// Request channel interfaces of the Lorenz Euler integrator.
interface lei_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [lei_pkg::LOAD_W-1:0]   load_x;
  logic signed [lei_pkg::LOAD_W-1:0]   load_y;
  logic signed [lei_pkg::LOAD_W-1:0]   load_z;

  modport source (output valid, op, load_x, load_y, load_z, input ready);
  modport sink   (input valid, op, load_x, load_y, load_z, output ready);
endinterface

interface lei_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lei_pkg::COORD_W-1:0]  pos_x;
  logic signed [lei_pkg::COORD_W-1:0]  pos_y;
  logic signed [lei_pkg::COORD_W-1:0]  pos_z;
  logic                                saturated;

  modport source (output valid, pos_x, pos_y, pos_z, saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, saturated, output ready);
endinterface

FILE: design/lei_mul.sv
// Shared signed multiplier with a registered product.
module lei_mul (
  input  logic                                clk,
  input  logic signed [lei_pkg::MUL_W-1:0]    a,
  input  logic signed [lei_pkg::MUL_W-1:0]    b,
  output logic signed [lei_pkg::PROD_W-1:0]   prod
);

  logic signed [lei_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= lei_pkg::PROD_W'(a) * lei_pkg::PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

FILE: design/lei_seq.sv
// Sequencer that walks one step request through the shared multiplier.
module lei_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            in_load,
  input  logic            out_free,
  output lei_pkg::ctrl_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_POST  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  lei_pkg::step_t  step_r, step_nxt;
  logic            cons_r;
  lei_pkg::step_t  cons_step_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_load ? S_POST : S_RUN;
          step_nxt  = lei_pkg::ST_DX;
        end
      end
      S_RUN: begin
        if (step_r == lei_pkg::ST_ZL) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = lei_pkg::step_t'(step_r + 4'd1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_POST;
      end
      S_POST: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= lei_pkg::ST_DX;
      cons_r      <= 1'b0;
      cons_step_r <= lei_pkg::ST_DX;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cons_r      <= (state_r == S_RUN);
      cons_step_r <= step_r;
    end
  end

  always_comb begin
    ctl.ready      = (state_r == S_IDLE);
    ctl.issue      = (state_r == S_RUN);
    ctl.issue_step = step_r;
    ctl.cons       = cons_r;
    ctl.cons_step  = cons_step_r;
    ctl.deliver    = (state_r == S_POST) && out_free;
  end

endmodule

FILE: design/lorenz_euler_integrator.sv
// Top level of the Lorenz Euler integrator: registers, point state and datapath.
//
// A step request passes from acceptance through the run, drain and post states of the
// sequencer; a load request goes straight to the post state. The block takes the next
// request in the cycle after the result is written to the output register, so a new
// request is never taken while one is in flight. A step is made of ten back-to-back
// passes through one shared 34x34 signed multiplier: four for the derivatives and two
// for each coordinate increment (derivative times dt split into a high and a low part),
// followed by a drain state for the product register and a post state for the result.
// The post state waits while the output register holds an untaken result. The output
// register holds a finished result while the next request is already being computed.
module lorenz_euler_integrator (
  input  logic                               clk,
  input  logic                               rst_n,
  lei_in_if.sink                             in_chan,
  lei_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [lei_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lei_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int CW = lei_pkg::COORD_W;

  // Configuration registers.
  logic [lei_pkg::SIGMA_W-1:0]        sigma_r;
  logic [lei_pkg::RHO_W-1:0]          rho_r;
  logic signed [lei_pkg::BETA_W-1:0]  beta_r;
  logic [lei_pkg::DT_W-1:0]           dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= lei_pkg::SIGMA_W'(655360);
      rho_r   <= lei_pkg::RHO_W'(2097152);
      beta_r  <= lei_pkg::BETA_W'(174763);
      dt_r    <= lei_pkg::DT_W'(16777);
    end else if (cfg_we) begin
      case (lei_pkg::reg_idx_t'(cfg_idx))
        lei_pkg::REG_SIGMA: sigma_r <= cfg_wdata[lei_pkg::SIGMA_W-1:0];
        lei_pkg::REG_RHO:   rho_r   <= cfg_wdata[lei_pkg::RHO_W-1:0];
        lei_pkg::REG_BETA:  beta_r  <= cfg_wdata[lei_pkg::BETA_W-1:0];
        lei_pkg::REG_DT:    dt_r    <= cfg_wdata[lei_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control.
  lei_pkg::ctrl_t ctl;
  logic           in_fire;
  logic           out_vld_r;
  logic           out_free;

  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_free       = !out_vld_r || out_chan.ready;
  assign in_chan.ready  = ctl.ready;

  lei_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_load  (in_chan.op),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // Point state and intermediates.
  logic signed [CW-1:0]                  px_r, py_r, pz_r;
  logic                                  flag_r;
  logic signed [lei_pkg::DER_W-1:0]      dx_r, dy_r, dz_r;
  logic signed [lei_pkg::ACC_W-1:0]      acc_r;

  // Operand selection for the shared multiplier.
  logic signed [lei_pkg::MUL_W-1:0]  sigma_al, rho_al, beta_al, dt_op;
  logic signed [CW:0]                d_yx;
  logic signed [lei_pkg::MUL_W-1:0]  d_rz;
  logic signed [lei_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [lei_pkg::DER_W-1:0]  der_sel;
  logic signed [lei_pkg::PROD_W-1:0] prod;

  assign sigma_al = lei_pkg::align_coef(lei_pkg::MUL_W'($signed({1'b0, sigma_r})));
  assign rho_al   = lei_pkg::align_coef(lei_pkg::MUL_W'($signed({1'b0, rho_r})));
  assign beta_al  = lei_pkg::align_coef(lei_pkg::MUL_W'(beta_r));
  assign dt_op    = lei_pkg::MUL_W'($signed({1'b0, dt_r}));
  assign d_yx     = (CW + 1)'(py_r) - (CW + 1)'(px_r);
  assign d_rz     = rho_al - lei_pkg::MUL_W'(pz_r);

  always_comb begin
    case (ctl.issue_step)
      lei_pkg::ST_XH, lei_pkg::ST_XL: der_sel = dx_r;
      lei_pkg::ST_YH, lei_pkg::ST_YL: der_sel = dy_r;
      default:                        der_sel = dz_r;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = dt_op;
    case (ctl.issue_step)
      lei_pkg::ST_DX: begin
        mul_a = sigma_al;
        mul_b = lei_pkg::MUL_W'(d_yx);
      end
      lei_pkg::ST_DYA: begin
        mul_a = lei_pkg::MUL_W'(px_r);
        mul_b = d_rz;
      end
      lei_pkg::ST_DZA: begin
        mul_a = lei_pkg::MUL_W'(px_r);
        mul_b = lei_pkg::MUL_W'(py_r);
      end
      lei_pkg::ST_DZB: begin
        mul_a = beta_al;
        mul_b = lei_pkg::MUL_W'(pz_r);
      end
      lei_pkg::ST_XH, lei_pkg::ST_YH, lei_pkg::ST_ZH: begin
        mul_a = lei_pkg::MUL_W'($signed(der_sel[lei_pkg::DER_W-1:lei_pkg::DT_FRAC]));
      end
      lei_pkg::ST_XL, lei_pkg::ST_YL, lei_pkg::ST_ZL: begin
        mul_a = {{(lei_pkg::MUL_W-lei_pkg::DT_FRAC){1'b0}}, der_sel[lei_pkg::DT_FRAC-1:0]};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  lei_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Product consumption. The increment is hi*dt + floor(lo*dt / 2^24), which equals the
  // floor of the whole derivative times dt over 2^24.
  logic signed [lei_pkg::DER_W-1:0] prod_sh;
  logic signed [lei_pkg::SUM_W-1:0] frac_add;
  logic signed [CW-1:0]             coord_sel;
  logic signed [lei_pkg::SUM_W-1:0] coord_sum;
  lei_pkg::sat_t                    coord_sat;
  lei_pkg::sat_t                    ld_x, ld_y, ld_z;

  assign prod_sh   = lei_pkg::DER_W'(prod >>> lei_pkg::FRAC_BITS);
  assign frac_add  = lei_pkg::SUM_W'(prod >>> lei_pkg::DT_FRAC);

  always_comb begin
    case (ctl.cons_step)
      lei_pkg::ST_XL: coord_sel = px_r;
      lei_pkg::ST_YL: coord_sel = py_r;
      default:        coord_sel = pz_r;
    endcase
  end

  assign coord_sum = lei_pkg::SUM_W'(coord_sel) + lei_pkg::SUM_W'(acc_r) + frac_add;
  assign coord_sat = lei_pkg::sat_coord(coord_sum);
  assign ld_x      = lei_pkg::sat_coord(lei_pkg::SUM_W'(in_chan.load_x));
  assign ld_y      = lei_pkg::sat_coord(lei_pkg::SUM_W'(in_chan.load_y));
  assign ld_z      = lei_pkg::sat_coord(lei_pkg::SUM_W'(in_chan.load_z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r   <= lei_pkg::COORD_ONE;
      py_r   <= lei_pkg::COORD_ONE;
      pz_r   <= lei_pkg::COORD_ONE;
      flag_r <= 1'b0;
    end else if (in_fire) begin
      if (in_chan.op) begin
        px_r   <= ld_x.val;
        py_r   <= ld_y.val;
        pz_r   <= ld_z.val;
        flag_r <= ld_x.clip || ld_y.clip || ld_z.clip;
      end else begin
        flag_r <= 1'b0;
      end
    end else if (ctl.cons) begin
      case (ctl.cons_step)
        lei_pkg::ST_XL: begin
          px_r   <= coord_sat.val;
          flag_r <= flag_r || coord_sat.clip;
        end
        lei_pkg::ST_YL: begin
          py_r   <= coord_sat.val;
          flag_r <= flag_r || coord_sat.clip;
        end
        lei_pkg::ST_ZL: begin
          pz_r   <= coord_sat.val;
          flag_r <= flag_r || coord_sat.clip;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cons) begin
      case (ctl.cons_step)
        lei_pkg::ST_DX:  dx_r <= prod_sh;
        lei_pkg::ST_DYA: dy_r <= prod_sh;
        lei_pkg::ST_DZA: begin
          dy_r <= dy_r - lei_pkg::DER_W'(py_r);
          dz_r <= prod_sh;
        end
        lei_pkg::ST_DZB: dz_r <= dz_r - prod_sh;
        lei_pkg::ST_XH, lei_pkg::ST_YH, lei_pkg::ST_ZH: begin
          acc_r <= lei_pkg::ACC_W'(prod);
        end
        default: ;
      endcase
    end
  end

  // Output register.
  logic signed [CW-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic                 sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.deliver) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.deliver) begin
      pos_x_r <= px_r;
      pos_y_r <= py_r;
      pos_z_r <= pz_r;
      sat_r   <= flag_r;
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.pos_x     = pos_x_r;
  assign out_chan.pos_y     = pos_y_r;
  assign out_chan.pos_z     = pos_z_r;
  assign out_chan.saturated = sat_r;

`ifndef SYNTHESIS
  // Once a request is taken, the block stays busy until its result is posted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_chan.ready)
    else $error("input ready right after an accepted request");

  // No product may still be pending while the block offers to take a request.
  a_idle_no_product: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !ctl.cons && !ctl.issue)
    else $error("multiplier work in flight while input is ready");

  // A new result appears only through the posting step of the sequencer.
  a_result_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(ctl.deliver))
    else $error("result valid raised without a posting step");
`endif

endmodule

FILE: sim/lei_tb_pkg.sv
`timescale 1ns / 1ps
// Request codes and the result record shared by the integrator testbench.
package lei_tb_pkg;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } lei_op_t;

  typedef struct packed {
    logic signed [lei_pkg::COORD_W-1:0] x;
    logic signed [lei_pkg::COORD_W-1:0] y;
    logic signed [lei_pkg::COORD_W-1:0] z;
    logic                               sat;
  } point_t;

endpackage

FILE: sim/lorenz_point_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the integrator's point after every request and compares results.
module lorenz_point_checker
  import lei_pkg::*;
  import lei_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  lei_in_if                    in_mon,
  lei_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   points_due
);

  typedef logic signed [63:0] wide_t;

  localparam wide_t WIDE_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam wide_t WIDE_MIN  = -WIDE_MAX - 64'sd1;
  localparam wide_t COORD_TOP = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
  localparam wide_t COORD_BOT = -COORD_TOP - 64'sd1;

  localparam wide_t SIGMA_RST = 64'sd655360;
  localparam wide_t RHO_RST   = 64'sd2097152;
  localparam wide_t BETA_RST  = 64'sd174763;
  localparam wide_t DT_RST    = 64'sd16777;

  wide_t  px, py, pz;
  wide_t  sigma_q, rho_q, beta_q, dt_q;
  logic   clipped;
  int     mismatches;
  point_t expected_points[$];

  function automatic wide_t clamp_wide(input logic signed [127:0] v);
    if (v[127:63] == '0 || v[127:63] == '1) return v[63:0];
    clipped = 1'b1;
    return v[127] ? WIDE_MIN : WIDE_MAX;
  endfunction

  function automatic wide_t add_sat(input wide_t a, input wide_t b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      clipped = 1'b1;
      return s[64] ? WIDE_MIN : WIDE_MAX;
    end
    return s[63:0];
  endfunction

  function automatic wide_t sub_sat(input wide_t a, input wide_t b);
    logic signed [64:0] s;
    s = a - b;
    if (s[64] != s[63]) begin
      clipped = 1'b1;
      return s[64] ? WIDE_MIN : WIDE_MAX;
    end
    return s[63:0];
  endfunction

  // The exact product is shifted arithmetically, which rounds toward minus infinity.
  function automatic wide_t mul_floor(input wide_t a, input wide_t b, input int sh);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p  = (wa * wb) >>> sh;
    return clamp_wide(p);
  endfunction

  function automatic wide_t align_q(input wide_t v);
    if (FRAC_BITS >= COEF_FRAC) return v <<< (FRAC_BITS - COEF_FRAC);
    return v >>> (COEF_FRAC - FRAC_BITS);
  endfunction

  function automatic wide_t clamp_coord(input wide_t v);
    if (v > COORD_TOP) begin
      clipped = 1'b1;
      return COORD_TOP;
    end
    if (v < COORD_BOT) begin
      clipped = 1'b1;
      return COORD_BOT;
    end
    return v;
  endfunction

  function automatic point_t advance_point(input lei_op_t op,
                                           input logic signed [LOAD_W-1:0] lx,
                                           input logic signed [LOAD_W-1:0] ly,
                                           input logic signed [LOAD_W-1:0] lz);
    wide_t  dx, dy, dz, nx, ny, nz;
    point_t r;
    clipped = 1'b0;
    if (op == OP_LOAD) begin
      px = clamp_coord(lx);
      py = clamp_coord(ly);
      pz = clamp_coord(lz);
    end else begin
      dx = mul_floor(align_q(sigma_q), sub_sat(py, px), FRAC_BITS);
      dy = sub_sat(mul_floor(px, sub_sat(align_q(rho_q), pz), FRAC_BITS), py);
      dz = sub_sat(mul_floor(px, py, FRAC_BITS), mul_floor(align_q(beta_q), pz, FRAC_BITS));
      nx = clamp_coord(add_sat(px, mul_floor(dx, dt_q, DT_FRAC)));
      ny = clamp_coord(add_sat(py, mul_floor(dy, dt_q, DT_FRAC)));
      nz = clamp_coord(add_sat(pz, mul_floor(dz, dt_q, DT_FRAC)));
      px = nx;
      py = ny;
      pz = nz;
    end
    r.x   = px[COORD_W-1:0];
    r.y   = py[COORD_W-1:0];
    r.z   = pz[COORD_W-1:0];
    r.sat = clipped;
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [COORD_W-1:0] want,
                             input logic signed [COORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    logic signed [BETA_W-1:0] beta_raw;
    point_t got, want;
    if (!rst_n) begin
      px      = {{(64-COORD_W){1'b0}}, COORD_ONE};
      py      = px;
      pz      = px;
      sigma_q = SIGMA_RST;
      rho_q   = RHO_RST;
      beta_q  = BETA_RST;
      dt_q    = DT_RST;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_SIGMA: sigma_q = cfg_wdata[SIGMA_W-1:0];
          REG_RHO:   rho_q   = cfg_wdata[RHO_W-1:0];
          REG_BETA: begin
            beta_raw = cfg_wdata[BETA_W-1:0];
            beta_q   = beta_raw;
          end
          REG_DT:    dt_q    = cfg_wdata[DT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_points.push_back(advance_point(lei_op_t'(in_mon.op), in_mon.load_x,
                                                in_mon.load_y, in_mon.load_z));
      if (out_mon.valid && out_mon.ready) begin
        got.x   = out_mon.pos_x;
        got.y   = out_mon.pos_y;
        got.z   = out_mon.pos_z;
        got.sat = out_mon.saturated;
        if (expected_points.size() == 0) begin
          $error("result with no request waiting: pos_x %0d, pos_y %0d, pos_z %0d",
                 got.x, got.y, got.z);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          check_field("pos_x", want.x, got.x);
          check_field("pos_y", want.y, got.y);
          check_field("pos_z", want.z, got.z);
          check_field("saturated", want.sat, got.sat);
        end
      end
    end
    errors     <= mismatches;
    points_due <= expected_points.size();
  end

endmodule

FILE: sim/lorenz_euler_integrator_tb.sv
`timescale 1ns / 1ps
// Testbench top of the Lorenz Euler integrator: clock, reset, stimulus and verdict.
module lorenz_euler_integrator_tb;
  import lei_pkg::*;
  import lei_tb_pkg::*;

  localparam int NEAR_SPAN    = 50 << FRAC_BITS;
  localparam int SETTLE_WAIT  = 20;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam logic signed [LOAD_W-1:0] LOAD_HI = {1'b0, {(LOAD_W-1){1'b1}}};
  localparam logic signed [LOAD_W-1:0] LOAD_LO = {1'b1, {(LOAD_W-1){1'b0}}};
  localparam logic signed [LOAD_W-1:0] LOAD_ONE = 1 << FRAC_BITS;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors;
  int                   points_due;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   sent = 0;

  lei_in_if  in_chan ();
  lei_out_if out_chan ();

  lorenz_euler_integrator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  lorenz_point_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .points_due (points_due)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic signed [LOAD_W-1:0] rand_near();
    return int'($urandom_range(2 * NEAR_SPAN)) - NEAR_SPAN;
  endfunction

  function automatic logic signed [LOAD_W-1:0] rand_any();
    case ($urandom_range(3))
      0: return LOAD_HI;
      1: return LOAD_LO;
      2: return $urandom_range(1) ? '0 : '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input lei_op_t op, input logic signed [LOAD_W-1:0] x,
                          input logic signed [LOAD_W-1:0] y,
                          input logic signed [LOAD_W-1:0] z);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.op     <= op;
    in_chan.load_x <= x;
    in_chan.load_y <= y;
    in_chan.load_z <= z;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
  endtask

  // The count from the checker is registered, so the task waits for a clock edge before trusting it.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (points_due != 0) @(posedge clk);
  endtask

  task automatic write_coefs(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] r,
                             input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] d);
    // Bits above each register's width are don't-care and get random fill half the time.
    if ($urandom_range(1)) s[CFG_W-1:SIGMA_W] = (CFG_W - SIGMA_W)'($urandom);
    if ($urandom_range(1)) r[CFG_W-1:RHO_W] = (CFG_W - RHO_W)'($urandom);
    if ($urandom_range(1)) b[CFG_W-1:BETA_W] = (CFG_W - BETA_W)'($urandom);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SIGMA;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_idx   <= REG_RHO;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_idx   <= REG_BETA;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_idx   <= REG_DT;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_coefs(input int ph);
    case (ph)
      1: write_coefs(655360, 1835008, 174763, 83886);
      2: write_coefs(5898240, 3932160, 1048576, 16777216);
      3: write_coefs(0, 0, -1048576, 0);
      4: write_coefs(23'h7FFFFF, 22'h3FFFFF, 22'h200000, 25'h1FFFFFF);
      5: write_coefs(CFG_W'($urandom_range(5898240)), CFG_W'($urandom_range(3932160)),
                     CFG_W'(int'($urandom_range(2097152)) - 1048576),
                     CFG_W'($urandom_range(16777216)));
      6: write_coefs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                     CFG_W'($urandom));
      7: write_coefs(655360, 2097152, 174763, 1677);
      default: ;
    endcase
  endtask

  task automatic directed();
    send_req(OP_STEP, '0, '0, '0);
    send_req(OP_STEP, LOAD_HI, LOAD_LO, LOAD_HI);
    send_req(OP_LOAD, LOAD_HI, LOAD_HI, LOAD_HI);
    send_req(OP_STEP, '0, '0, '0);
    send_req(OP_LOAD, LOAD_LO, LOAD_LO, LOAD_LO);
    send_req(OP_STEP, '1, '1, '1);
    send_req(OP_LOAD, '0, '0, '0);
    send_req(OP_STEP, LOAD_LO, LOAD_HI, LOAD_LO);
    send_req(OP_LOAD, '1, '1, '1);
    send_req(OP_STEP, '0, '0, '0);
    send_req(OP_LOAD, LOAD_HI, LOAD_LO, '0);
    send_req(OP_STEP, '0, '0, '0);
    send_req(OP_LOAD, LOAD_LO, LOAD_HI, LOAD_HI);
    send_req(OP_STEP, '0, '0, '0);
    send_req(OP_LOAD, LOAD_ONE, LOAD_ONE, LOAD_ONE);
    send_req(OP_STEP, '0, '0, '0);
    send_req(OP_STEP, '0, '0, '0);
    send_req(OP_LOAD, -LOAD_ONE, LOAD_ONE, 32'sh0019_0000);
    send_req(OP_STEP, $urandom, $urandom, $urandom);
  endtask

  // Mostly a load near the attractor followed by a run of steps; the rest is rougher.
  task automatic run_burst();
    int steps;
    if ($urandom_range(99) < 80) begin
      send_req(OP_LOAD, rand_near(), rand_near(), rand_near());
      steps = $urandom_range(30, 5);
    end else begin
      send_req(OP_LOAD, rand_any(), rand_any(), rand_any());
      steps = $urandom_range(3);
    end
    repeat (steps) send_req(OP_STEP, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int target;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_SIGMA;
    cfg_wdata       <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.op      <= OP_STEP;
    in_chan.load_x  <= '0;
    in_chan.load_y  <= '0;
    in_chan.load_z  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_coefs(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      if (ph == 0) directed();
      target = sent + PHASE_ITEMS;
      while (sent < target) run_burst();
    end

    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (errors == 0 && points_due == 0) begin
      $display("[lorenz_euler_integrator] OK");
    end else begin
      $display("[lorenz_euler_integrator] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[lorenz_euler_integrator] ERROR");
    $finish;
  end

endmodule
